### rtl/liss_pkg.sv
// Package for the ladder idle state selector.
// Holds the beat kinds, register indexes, configuration struct and latency lookup.
// No dependencies.
package liss_pkg;

	typedef enum logic [1:0] {
		KIND_SELECT  = 2'd0,
		KIND_REFLECT = 2'd1,
		KIND_ENABLE  = 2'd2,
		KIND_NOP     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_NUM_STATES     = 3'd0,
		REG_FIRST_STATE    = 3'd1,
		REG_PROMOTE_COUNT  = 3'd2,
		REG_DEMOTE_COUNT   = 3'd3,
		REG_EXIT_LAT_LO    = 3'd4,
		REG_EXIT_LAT_HI    = 3'd5,
		REG_DISABLE_MASK   = 3'd6,
		REG_TIME_VALID     = 3'd7
	} reg_idx_t;

	localparam int unsigned ADDR_W = 6;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned LAT_W  = 16;
	localparam int unsigned CNT_W  = 8;
	localparam int unsigned NUM_LAT = 8;

	typedef struct packed {
		logic [3:0]        num_states;
		logic              first_state;
		logic [CNT_W-1:0]  promote_count;
		logic [CNT_W-1:0]  demote_count;
		logic [63:0]       exit_lat_lo;
		logic [63:0]       exit_lat_hi;
		logic [7:0]        disable_mask;
		logic [7:0]        time_valid_mask;
	} cfg_t;

	function automatic logic [LAT_W-1:0] lat_of(input cfg_t c, input logic [2:0] i);
		logic [63:0] w;
		w = i[2] ? c.exit_lat_hi : c.exit_lat_lo;
		return w[LAT_W*i[1:0] +: LAT_W];
	endfunction

endpackage

### rtl/ladder_idle_state_selector_unit.sv
// Top level of the ladder idle state selector: input register, decision logic, result register.
// Depends on liss_pkg and liss_regs.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------------
//  in       | in_valid / in_ready    | kind, latency_limit, last_residency, entered_index
//  out      | out_valid / out_ready  | state_index
//  cfg      | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// A beat passes the input register, then the result register; one beat per cycle sustained while out_ready is high.
// The ladder state and counters update as the item leaves the input register,
// so each decision sees the previous one's outcome with no bubble.
// Reset puts the ladder on state 1 with all counters clear.
// A stalled result holds the input register; in_ready drops only when both are full.
module ladder_idle_state_selector_unit import liss_pkg::*; #(
	parameter int MAX_STATES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [15:0]       latency_limit,
	input  logic [23:0]       last_residency,
	input  logic [2:0]        entered_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        state_index
);

	localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam logic [3:0] MAX_N   = 4'(MAX_STATES);
	localparam logic [2:0] MAX_IDX = 3'(MAX_STATES - 1);

	cfg_t cfg;

	liss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic             valid_s1;
	kind_t            kind_s1;
	logic [15:0]      limit_s1;
	logic [23:0]      res_s1;
	logic [2:0]       entered_s1;
	logic             advance;
	logic             out_valid_q;
	logic [2:0]       state_index_q;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1    <= KIND_NOP;
			limit_s1   <= '0;
			res_s1     <= '0;
			entered_s1 <= '0;
		end else if (in_ready && in_valid) begin
			kind_s1    <= kind_t'(kind);
			limit_s1   <= latency_limit;
			res_s1     <= last_residency;
			entered_s1 <= entered_index;
		end
	end

	// ladder state
	logic [2:0]       cur_q;
	logic [CNT_W-1:0] pc_q [MAX_STATES];
	logic [CNT_W-1:0] dc_q [MAX_STATES];

	logic [2:0]       first3;
	logic [3:0]       n_eff;
	logic [2:0]       nxt_idx;
	logic [15:0]      thr;
	logic [16:0]      thr2;
	logic             tvalid;
	logic             is_long;
	logic             is_short;
	logic             above_first;
	logic             prom_ok;
	logic             prom_move;
	logic             drop_ok;
	logic [2:0]       drop_idx;
	logic [CNT_W-1:0] pc_cur;
	logic [CNT_W-1:0] dc_cur;
	logic [CNT_W-1:0] pc_bump;
	logic [CNT_W-1:0] dc_bump;

	assign first3      = {2'b00, cfg.first_state};
	assign n_eff       = (cfg.num_states > MAX_N) ? MAX_N : cfg.num_states;
	assign nxt_idx     = cur_q + 3'd1;
	assign thr         = lat_of(cfg, cur_q);
	assign thr2        = {thr, 1'b0};
	assign tvalid      = cfg.time_valid_mask[cur_q];
	// residency minus latency compared against latency
	assign is_long     = ~tvalid | (res_s1 > {7'd0, thr2});
	assign is_short    = tvalid & (res_s1 < {7'd0, thr2});
	assign above_first = cur_q > first3;
	assign pc_cur      = pc_q[cur_q[IDX_W-1:0]];
	assign dc_cur      = dc_q[cur_q[IDX_W-1:0]];
	assign pc_bump     = (pc_cur == 8'hFF) ? pc_cur : pc_cur + 8'd1;
	assign dc_bump     = (dc_cur == 8'hFF) ? dc_cur : dc_cur + 8'd1;
	assign prom_ok     = (({1'b0, cur_q} + 4'd1) < n_eff) && !cfg.disable_mask[nxt_idx]
		&& is_long && (lat_of(cfg, nxt_idx) <= limit_s1);
	assign prom_move   = prom_ok && (pc_bump >= cfg.promote_count);
	assign drop_ok     = above_first && (cfg.disable_mask[cur_q] || thr > limit_s1);

	// deepest lower state that fits the limit, else first state
	always_comb begin
		drop_idx = first3;
		for (int j = 0; j < NUM_LAT; j++) begin
			if (3'(j) < cur_q && 3'(j) > first3 && lat_of(cfg, 3'(j)) <= limit_s1) begin
				drop_idx = 3'(j);
			end
		end
	end

	logic [2:0]       next_cur;
	logic             cnt_we;
	logic [CNT_W-1:0] pc_wd;
	logic [CNT_W-1:0] dc_wd;
	logic             en_clr;

	always_comb begin
		next_cur = cur_q;
		cnt_we   = 1'b0;
		pc_wd    = pc_cur;
		dc_wd    = dc_cur;
		en_clr   = 1'b0;
		unique case (kind_s1)
			KIND_SELECT: begin
				cnt_we = 1'b1;
				if (limit_s1 == 16'd0) begin
					next_cur = 3'd0;
					pc_wd    = '0;
					dc_wd    = '0;
				end else if (prom_move) begin
					next_cur = nxt_idx;
					pc_wd    = '0;
					dc_wd    = '0;
				end else if (drop_ok) begin
					next_cur = drop_idx;
					pc_wd    = '0;
					dc_wd    = '0;
				end else if (prom_ok) begin
					pc_wd = pc_bump;
					dc_wd = '0;
				end else if (above_first && is_short) begin
					if (dc_bump >= cfg.demote_count) begin
						next_cur = cur_q - 3'd1;
						pc_wd    = '0;
						dc_wd    = '0;
					end else begin
						pc_wd = '0;
						dc_wd = dc_bump;
					end
				end else begin
					cnt_we = 1'b0;
				end
			end
			KIND_REFLECT: begin
				if (entered_s1 != 3'd0) begin
					next_cur = (entered_s1 > MAX_IDX) ? MAX_IDX : entered_s1;
				end
			end
			KIND_ENABLE: begin
				next_cur = first3;
				en_clr   = 1'b1;
			end
			KIND_NOP: begin
				next_cur = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= 3'd1;
			for (int k = 0; k < MAX_STATES; k++) begin
				pc_q[k] <= '0;
				dc_q[k] <= '0;
			end
		end else if (advance) begin
			cur_q <= next_cur;
			for (int k = 0; k < MAX_STATES; k++) begin
				if (en_clr && 4'(k) < n_eff && 3'(k) >= first3) begin
					pc_q[k] <= '0;
					dc_q[k] <= '0;
				end else if (cnt_we && 3'(k) == cur_q) begin
					pc_q[k] <= pc_wd;
					dc_q[k] <= dc_wd;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_index_q <= next_cur;
		end
	end

	assign out_valid   = out_valid_q;
	assign state_index = state_index_q;

	a_cur_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= MAX_IDX)
		else $error("ladder state beyond last state");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> state_index_q == cur_q)
		else $error("result beat differs from ladder state");

	a_zero_limit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_SELECT && limit_s1 == 16'd0 |=> cur_q == 3'd0)
		else $error("zero latency limit did not force state 0");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result slot");

endmodule

### rtl/liss_regs.sv
// Configuration register file of the ladder idle state selector, APB-style access.
// Depends on liss_pkg.
module liss_regs import liss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_states      <= 4'd8;
			cfg_q.first_state     <= 1'b1;
			cfg_q.promote_count   <= 8'd4;
			cfg_q.demote_count    <= 8'd1;
			cfg_q.exit_lat_lo     <= '0;
			cfg_q.exit_lat_hi     <= '0;
			cfg_q.disable_mask    <= '0;
			cfg_q.time_valid_mask <= 8'hFF;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_NUM_STATES:    cfg_q.num_states      <= pwdata[3:0];
				REG_FIRST_STATE:   cfg_q.first_state     <= pwdata[0];
				REG_PROMOTE_COUNT: cfg_q.promote_count   <= pwdata[7:0];
				REG_DEMOTE_COUNT:  cfg_q.demote_count    <= pwdata[7:0];
				REG_EXIT_LAT_LO:   cfg_q.exit_lat_lo     <= pwdata;
				REG_EXIT_LAT_HI:   cfg_q.exit_lat_hi     <= pwdata;
				REG_DISABLE_MASK:  cfg_q.disable_mask    <= pwdata[7:0];
				REG_TIME_VALID:    cfg_q.time_valid_mask <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_NUM_STATES:    prdata = {60'd0, cfg_q.num_states};
			REG_FIRST_STATE:   prdata = {63'd0, cfg_q.first_state};
			REG_PROMOTE_COUNT: prdata = {56'd0, cfg_q.promote_count};
			REG_DEMOTE_COUNT:  prdata = {56'd0, cfg_q.demote_count};
			REG_EXIT_LAT_LO:   prdata = cfg_q.exit_lat_lo;
			REG_EXIT_LAT_HI:   prdata = cfg_q.exit_lat_hi;
			REG_DISABLE_MASK:  prdata = {56'd0, cfg_q.disable_mask};
			REG_TIME_VALID:    prdata = {56'd0, cfg_q.time_valid_mask};
		endcase
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for ladder_idle_state_selector_unit: directed rows, then random phases.
// Keeps its own model of the ladder (rung, hit counters, config) and checks every result beat.
// Depends on liss_pkg and the RTL of the unit.
module testbench import liss_pkg::*; ();

	localparam int IDLE_LIMIT    = 1000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 95;
	localparam int NUM_DIR       = 26;
	localparam int DIR_SPLIT     = 10;

	typedef struct packed {
		kind_t       k;
		logic [15:0] lim;
		logic [23:0] res;
		logic [2:0]  ent;
		logic        typed;
		logic [2:0]  want;
	} stim_row_t;

	// rows before DIR_SPLIT run on reset config; the rest on the directed config
	localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
		'{KIND_NOP,     16'h1234, 24'h000000, 3'd5, 1'b1, 3'd1},
		'{KIND_REFLECT, 16'h0000, 24'h000000, 3'd0, 1'b1, 3'd1},
		'{KIND_REFLECT, 16'h0000, 24'h000000, 3'd7, 1'b1, 3'd7},
		'{KIND_SELECT,  16'h0000, 24'hFFFFFF, 3'd0, 1'b1, 3'd0},
		'{KIND_ENABLE,  16'hFFFF, 24'hFFFFFF, 3'd7, 1'b1, 3'd1},
		'{KIND_SELECT,  16'hFFFF, 24'hFFFFFF, 3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'hFFFF, 24'hFFFFFF, 3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'hFFFF, 24'hFFFFFF, 3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'hFFFF, 24'hFFFFFF, 3'd0, 1'b0, 3'd0},
		'{KIND_REFLECT, 16'h0000, 24'h000000, 3'd3, 1'b1, 3'd3},
		'{KIND_ENABLE,  16'h0000, 24'h000000, 3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'd1000, 24'd100,    3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'd1000, 24'd100,    3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'd1000, 24'd10,     3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'd1000, 24'd10,     3'd0, 1'b0, 3'd0},
		'{KIND_REFLECT, 16'h0000, 24'h000000, 3'd3, 1'b0, 3'd0},
		'{KIND_SELECT,  16'd1000, 24'd0,      3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'd1000, 24'd0,      3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'd50,   24'd5000,   3'd0, 1'b0, 3'd0},
		'{KIND_REFLECT, 16'h0000, 24'h000000, 3'd5, 1'b0, 3'd0},
		'{KIND_SELECT,  16'hFFFF, 24'd100000, 3'd0, 1'b0, 3'd0},
		'{KIND_REFLECT, 16'h0000, 24'h000000, 3'd5, 1'b0, 3'd0},
		'{KIND_SELECT,  16'd10,   24'd0,      3'd0, 1'b0, 3'd0},
		'{KIND_REFLECT, 16'h0000, 24'h000000, 3'd7, 1'b0, 3'd0},
		'{KIND_SELECT,  16'hFFFF, 24'hFFFFFF, 3'd0, 1'b0, 3'd0},
		'{KIND_SELECT,  16'hFFFE, 24'hFFFFFF, 3'd0, 1'b0, 3'd0}
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        kind;
	logic [15:0]       latency_limit;
	logic [23:0]       last_residency;
	logic [2:0]        entered_index;
	logic              out_valid;
	logic              out_ready;
	logic [2:0]        state_index;

	cfg_t       shadow;
	logic [2:0] rung;
	logic [7:0] deeper_hits [8];
	logic [7:0] shallower_hits [8];
	logic [2:0] expected_rungs [$];
	int         errors = 0;
	int         idle_cycles = 0;
	bit         hold_req = 0;

	ladder_idle_state_selector_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.latency_limit(latency_limit), .last_residency(last_residency),
		.entered_index(entered_index),
		.out_valid(out_valid), .out_ready(out_ready), .state_index(state_index)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int exit_us(int s);
		logic [127:0] lat_words;
		lat_words = {shadow.exit_lat_hi, shadow.exit_lat_lo};
		return int'(lat_words[s*16 +: 16]);
	endfunction

	function automatic int rung_count();
		return (shadow.num_states > 4'd8) ? 8 : int'(shadow.num_states);
	endfunction

	function automatic logic [7:0] sat_inc(logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

	function automatic void leave_rung(int from, int to);
		deeper_hits[from] = 8'd0;
		shallower_hits[from] = 8'd0;
		rung = 3'(to);
	endfunction

	function automatic logic [2:0] decide_rung(logic [15:0] lim, logic [23:0] res);
		int     cur_i;
		int     first;
		int     n;
		int     i;
		longint thr;
		longint meas;
		longint limit;
		cur_i = rung;
		first = shadow.first_state;
		n = rung_count();
		thr = exit_us(cur_i);
		limit = lim;
		if (limit == 0) begin
			leave_rung(cur_i, 0);
			return rung;
		end
		// untrusted residency always reads as long
		if (shadow.time_valid_mask[cur_i])
			meas = longint'(res) - thr;
		else
			meas = thr + 1;
		if (cur_i < n - 1 && !shadow.disable_mask[cur_i + 1] && meas > thr &&
				exit_us(cur_i + 1) <= limit) begin
			deeper_hits[cur_i] = sat_inc(deeper_hits[cur_i]);
			shallower_hits[cur_i] = 8'd0;
			if (deeper_hits[cur_i] >= shadow.promote_count) begin
				leave_rung(cur_i, cur_i + 1);
				return rung;
			end
		end
		if (cur_i > first && (shadow.disable_mask[cur_i] || thr > limit)) begin
			for (i = cur_i - 1; i > first; i--)
				if (exit_us(i) <= limit)
					break;
			leave_rung(cur_i, i);
			return rung;
		end
		if (cur_i > first && meas < thr) begin
			shallower_hits[cur_i] = sat_inc(shallower_hits[cur_i]);
			deeper_hits[cur_i] = 8'd0;
			if (shallower_hits[cur_i] >= shadow.demote_count)
				leave_rung(cur_i, cur_i - 1);
		end
		return rung;
	endfunction

	function automatic logic [2:0] advance_ladder(kind_t k, logic [15:0] lim,
			logic [23:0] res, logic [2:0] ent);
		int i;
		case (k)
			KIND_SELECT: begin
				return decide_rung(lim, res);
			end
			KIND_REFLECT: begin
				if (ent != 3'd0)
					rung = ent;
			end
			KIND_ENABLE: begin
				rung = 3'(shadow.first_state);
				for (i = shadow.first_state; i < rung_count(); i++) begin
					deeper_hits[i] = 8'd0;
					shallower_hits[i] = 8'd0;
				end
			end
			default: ;
		endcase
		return rung;
	endfunction

	task automatic report(string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic send_beat(kind_t k, logic [15:0] lim, logic [23:0] res, logic [2:0] ent,
			logic typed, logic [2:0] want);
		logic [2:0] predicted;
		in_valid <= 1'b1;
		kind <= k;
		latency_limit <= lim;
		last_residency <= res;
		entered_index <= ent;
		do @(posedge clk); while (!in_ready);
		predicted = advance_ladder(k, lim, res, ent);
		expected_rungs.push_back(typed ? want : predicted);
	endtask

	task automatic sender_gap(bit steady);
		int r;
		int len;
		r = $urandom_range(0, 99);
		len = 0;
		if (!steady) begin
			if (r >= 95)
				len = $urandom_range(8, 30);
			else if (r >= 70)
				len = $urandom_range(1, 3);
		end
		if (len > 0) begin
			in_valid <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_rungs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic program_cfg(cfg_t c);
		write_reg(REG_NUM_STATES, 64'(c.num_states));
		write_reg(REG_FIRST_STATE, 64'(c.first_state));
		write_reg(REG_PROMOTE_COUNT, 64'(c.promote_count));
		write_reg(REG_DEMOTE_COUNT, 64'(c.demote_count));
		write_reg(REG_EXIT_LAT_LO, c.exit_lat_lo);
		write_reg(REG_EXIT_LAT_HI, c.exit_lat_hi);
		write_reg(REG_DISABLE_MASK, 64'(c.disable_mask));
		write_reg(REG_TIME_VALID, 64'(c.time_valid_mask));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow = c;
	endtask

	function automatic cfg_t random_cfg();
		cfg_t          c;
		logic [15:0]   lat [8];
		int unsigned   sum;
		int            i;
		c.num_states = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(2, 8));
		c.first_state = 1'($urandom_range(0, 1));
		c.promote_count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(1, 4));
		c.demote_count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(1, 4));
		if ($urandom_range(0, 9) < 7) begin
			lat[0] = 16'($urandom_range(0, 5));
			for (i = 1; i < 8; i++) begin
				sum = lat[i - 1] + $urandom_range(0, 400);
				lat[i] = (sum > 65535) ? 16'hFFFF : 16'(sum);
			end
		end else begin
			for (i = 0; i < 8; i++)
				lat[i] = 16'($urandom);
		end
		c.exit_lat_lo = {lat[3], lat[2], lat[1], lat[0]};
		c.exit_lat_hi = {lat[7], lat[6], lat[5], lat[4]};
		if ($urandom_range(0, 2) == 0)
			c.disable_mask = 8'($urandom);
		else if ($urandom_range(0, 1) == 1)
			c.disable_mask = 8'(1 << $urandom_range(0, 7));
		else
			c.disable_mask = 8'h00;
		c.time_valid_mask = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF;
		return c;
	endfunction

	task automatic random_beat(bit steady);
		kind_t       k;
		logic [15:0] lim;
		logic [23:0] res;
		int          r;
		int          thr;
		int          tmp;
		r = $urandom_range(0, 99);
		if (r < 75)
			k = KIND_SELECT;
		else if (r < 85)
			k = KIND_REFLECT;
		else if (r < 93)
			k = KIND_ENABLE;
		else
			k = KIND_NOP;
		r = $urandom_range(0, 9);
		if (r == 0)
			lim = 16'h0000;
		else if (r == 1)
			lim = 16'hFFFF;
		else if (r < 4)
			lim = 16'($urandom);
		else begin
			tmp = exit_us($urandom_range(0, 7)) + $urandom_range(0, 50);
			lim = (tmp > 65535) ? 16'hFFFF : 16'(tmp);
		end
		// aim residency around twice the current rung's exit latency
		thr = exit_us(rung);
		r = $urandom_range(0, 9);
		if (r == 0)
			res = 24'h000000;
		else if (r == 1)
			res = 24'hFFFFFF;
		else if (r < 4)
			res = 24'($urandom);
		else begin
			if ($urandom_range(0, 1) == 1)
				tmp = 2 * thr + $urandom_range(1, 300);
			else
				tmp = $urandom_range(0, 2 * thr);
			res = 24'(tmp);
		end
		send_beat(k, lim, res, 3'($urandom), 1'b0, 3'd0);
		sender_gap(steady);
	endtask

	always @(posedge clk) begin : result_check
		logic [2:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rungs.size() == 0) begin
				report($sformatf("state_index %0d with nothing expected", state_index));
			end else begin
				want = expected_rungs.pop_front();
				if (state_index !== want)
					report($sformatf("state_index %0d, expected %0d", state_index, want));
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL ladder_idle_state_selector_unit");
			$finish;
		end
	end

	initial begin : receiver
		int r;
		int len;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_req = 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready <= 1'b1;
					len = $urandom_range(1, 40);
				end else if (r < 92) begin
					out_ready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					len = $urandom_range(8, 30);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		cfg_t c;
		int   p;
		int   j;
		bit   steady;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		kind = KIND_NOP;
		latency_limit = '0;
		last_residency = '0;
		entered_index = '0;
		out_ready = 1'b0;
		shadow.num_states = 4'd8;
		shadow.first_state = 1'b1;
		shadow.promote_count = 8'd4;
		shadow.demote_count = 8'd1;
		shadow.exit_lat_lo = '0;
		shadow.exit_lat_hi = '0;
		shadow.disable_mask = 8'h00;
		shadow.time_valid_mask = 8'hFF;
		rung = 3'd1;
		for (j = 0; j < 8; j++) begin
			deeper_hits[j] = 8'd0;
			shallower_hits[j] = 8'd0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (j = 0; j < NUM_DIR; j++) begin
			if (j == DIR_SPLIT) begin
				drain();
				c.num_states = 4'd6;
				c.first_state = 1'b0;
				c.promote_count = 8'd2;
				c.demote_count = 8'd2;
				c.exit_lat_lo = {16'd300, 16'd100, 16'd20, 16'd0};
				c.exit_lat_hi = {16'hFFFF, 16'd5000, 16'd2000, 16'd800};
				c.disable_mask = 8'b0010_0000;
				c.time_valid_mask = 8'b1111_0111;
				program_cfg(c);
			end
			send_beat(DIR_ROWS[j].k, DIR_ROWS[j].lim, DIR_ROWS[j].res, DIR_ROWS[j].ent,
				DIR_ROWS[j].typed, DIR_ROWS[j].want);
			sender_gap(1'b0);
		end

		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			if (p == 0) begin
				c.num_states = 4'd8;
				c.first_state = 1'b1;
				c.promote_count = 8'd255;
				c.demote_count = 8'd255;
				c.exit_lat_lo = '1;
				c.exit_lat_hi = '1;
				c.disable_mask = 8'hFF;
				c.time_valid_mask = 8'h00;
			end else if (p == 1) begin
				c.num_states = 4'd1;
				c.first_state = 1'b0;
				c.promote_count = 8'd1;
				c.demote_count = 8'd1;
				c.exit_lat_lo = '0;
				c.exit_lat_hi = '0;
				c.disable_mask = 8'h00;
				c.time_valid_mask = 8'hFF;
			end else begin
				c = random_cfg();
			end
			program_cfg(c);
			steady = (p == 3) || (p % 4 == 2);
			// long receiver stall while the sender keeps offering beats
			if (p == 3)
				hold_req = 1;
			for (j = 0; j < PHASE_ITEMS; j++)
				random_beat(steady);
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS ladder_idle_state_selector_unit");
		else
			$display("FAIL ladder_idle_state_selector_unit");
		$finish;
	end

endmodule

### sim.f
rtl/liss_pkg.sv
rtl/liss_regs.sv
rtl/ladder_idle_state_selector_unit.sv
tb/testbench.sv
